### sv/bps_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the bilinear pixel sampler.
package bps_pkg;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;

	localparam int COORD_W  = 12;
	localparam int FRAC_W   = 4;
	localparam int INT_W    = COORD_W - FRAC_W;
	localparam int PIXEL_W  = 32;
	localparam int CH_W     = 8;
	localparam int NUM_CH   = PIXEL_W / CH_W;
	localparam int SIZE_W   = 13;
	localparam int CFG_W    = 9;
	localparam int CFG_IDX_W = 1;
	localparam int WGT_W    = FRAC_W + 1;
	localparam int WPROD_W  = 2 * FRAC_W + 1;
	localparam int ACC_W    = 2 * CH_W;

	localparam logic [WGT_W-1:0] WEIGHT_ONE = WGT_W'(16);
	localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(256);

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SAMPLE = 1'b1
	} bps_op_t;

	typedef struct packed {
		bps_op_t              opcode;
		logic [COORD_W-1:0]   coord_x_q4;
		logic [COORD_W-1:0]   coord_y_q4;
		logic [PIXEL_W-1:0]   pixel_value;
	} bps_in_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] sampled_color;
	} bps_out_t;

	typedef struct packed {
		logic               is_sample;
		logic [INT_W-1:0]   x0;
		logic [INT_W-1:0]   y0;
		logic [INT_W:0]     x1;
		logic [INT_W:0]     y1;
		logic [FRAC_W-1:0]  fx;
		logic [FRAC_W-1:0]  fy;
		logic [PIXEL_W-1:0] pixel;
	} bps_cmd_t;

endpackage

### sv/bps_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interface carrying one payload per transaction.
interface bps_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### sv/bps_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
module bps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;
endmodule

### sv/bps_queue.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
module bps_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bps_pkg::bps_cmd_t push_data,
	output logic              full,
	input  logic              pop,
	output bps_pkg::bps_cmd_t head,
	output logic              head_valid
);
	import bps_pkg::*;

	bps_cmd_t           entry_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

### sv/bps_front.sv
`timescale 1ns / 1ps
// Front end: size registers, input acceptance and coordinate clamping.
module bps_front #(
	parameter int MAX_WIDTH  = bps_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bps_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bps_pkg::CFG_W-1:0]       cfg_wdata,
	bps_stream_if.sink                      req,
	input  logic                            q_full,
	output logic                            push,
	output bps_pkg::bps_cmd_t               cmd
);
	import bps_pkg::*;

	logic [CFG_W-1:0]  width_q;
	logic [CFG_W-1:0]  height_q;
	logic [SIZE_W-1:0] ew;
	logic [SIZE_W-1:0] eh;
	logic [SIZE_W-1:0] xi;
	logic [SIZE_W-1:0] yi;
	logic [SIZE_W-1:0] x0w;
	logic [SIZE_W-1:0] y0w;
	logic [SIZE_W-1:0] x1w;
	logic [SIZE_W-1:0] y1w;
	logic              is_sample;
	logic              in_store;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_RESET;
			height_q <= SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_wdata;
				REG_IMAGE_HEIGHT: height_q <= cfg_wdata;
				default:          width_q  <= width_q;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			ew = SIZE_W'(1);
		end else if (SIZE_W'(width_q) > SIZE_W'(MAX_WIDTH)) begin
			ew = SIZE_W'(MAX_WIDTH);
		end else begin
			ew = SIZE_W'(width_q);
		end
		if (height_q == '0) begin
			eh = SIZE_W'(1);
		end else if (SIZE_W'(height_q) > SIZE_W'(MAX_HEIGHT)) begin
			eh = SIZE_W'(MAX_HEIGHT);
		end else begin
			eh = SIZE_W'(height_q);
		end
	end

	always_comb begin
		xi = SIZE_W'(req.payload.coord_x_q4[COORD_W-1:FRAC_W]);
		yi = SIZE_W'(req.payload.coord_y_q4[COORD_W-1:FRAC_W]);
		x0w = (xi >= ew) ? ew - 1'b1 : xi;
		y0w = (yi >= eh) ? eh - 1'b1 : yi;
		x1w = x0w + 1'b1;
		y1w = y0w + 1'b1;
		if (x1w >= ew) begin
			x1w = x0w;
		end
		if (y1w >= eh) begin
			y1w = y0w;
		end
	end

	assign is_sample = (req.payload.opcode == OP_SAMPLE);
	assign in_store  = (xi < SIZE_W'(MAX_WIDTH)) && (yi < SIZE_W'(MAX_HEIGHT));

	assign req.ready = !q_full;
	assign push      = req.valid && !q_full && (is_sample || in_store);

	always_comb begin
		cmd.is_sample = is_sample;
		cmd.x0        = is_sample ? x0w[INT_W-1:0] : xi[INT_W-1:0];
		cmd.y0        = is_sample ? y0w[INT_W-1:0] : yi[INT_W-1:0];
		cmd.x1        = x1w[INT_W:0];
		cmd.y1        = y1w[INT_W:0];
		cmd.fx        = req.payload.coord_x_q4[FRAC_W-1:0];
		cmd.fy        = req.payload.coord_y_q4[FRAC_W-1:0];
		cmd.pixel     = req.payload.pixel_value;
	end
endmodule

### sv/bps_back.sv
`timescale 1ns / 1ps
// Back end: memory sequencing, weighted accumulation and result register.
module bps_back #(
	parameter int MAX_WIDTH  = bps_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bps_pkg::DEF_MAX_HEIGHT,
	parameter int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bps_pkg::bps_cmd_t             head,
	input  logic                          head_valid,
	output logic                          pop,
	output logic                          ram_we,
	output logic [AW-1:0]                 ram_addr,
	output logic [bps_pkg::PIXEL_W-1:0]   ram_wdata,
	input  logic [bps_pkg::PIXEL_W-1:0]   ram_rdata,
	bps_stream_if.source                  rsp
);
	import bps_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	state_t             state_q;
	logic [1:0]         cnt_q;
	bps_cmd_t           cmd_q;
	logic               rd_vld_s1;
	logic               rd_first_s1;
	logic               rd_last_s1;
	logic [WPROD_W-1:0] w_s1;
	logic [ACC_W-1:0]   acc_q [NUM_CH];
	logic [ACC_W-1:0]   acc_next [NUM_CH];
	logic               out_valid_q;
	logic [PIXEL_W-1:0] out_data_q;
	logic [PIXEL_W-1:0] result;
	logic [INT_W:0]     xsel;
	logic [INT_W:0]     ysel;
	logic [WGT_W-1:0]   wx;
	logic [WGT_W-1:0]   wy;
	logic [2*WGT_W-1:0] wprod;
	logic               take;

	assign take = state_q == ST_IDLE && head_valid && head.is_sample
		&& (!out_valid_q || rsp.ready) && !rd_vld_s1;
	assign ram_we = state_q == ST_IDLE && head_valid && !head.is_sample;
	assign pop    = ram_we || take;
	assign ram_wdata = head.pixel;

	always_comb begin
		if (state_q == ST_READ) begin
			xsel = cnt_q[0] ? cmd_q.x1 : {1'b0, cmd_q.x0};
			ysel = cnt_q[1] ? cmd_q.y1 : {1'b0, cmd_q.y0};
		end else begin
			xsel = {1'b0, head.x0};
			ysel = {1'b0, head.y0};
		end
		ram_addr = AW'(ysel) * AW'(MAX_WIDTH) + AW'(xsel);
	end

	always_comb begin
		wx = cnt_q[0] ? {1'b0, cmd_q.fx} : WEIGHT_ONE - {1'b0, cmd_q.fx};
		wy = cnt_q[1] ? {1'b0, cmd_q.fy} : WEIGHT_ONE - {1'b0, cmd_q.fy};
		wprod = (2*WGT_W)'(wx) * (2*WGT_W)'(wy);
	end

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			acc_next[c] = (rd_first_s1 ? '0 : acc_q[c])
				+ ACC_W'(ram_rdata[c*CH_W +: CH_W]) * ACC_W'(w_s1);
			result[c*CH_W +: CH_W] = acc_next[c][ACC_W-1:CH_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			cmd_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rd_first_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			w_s1        <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			for (int c = 0; c < NUM_CH; c++) begin
				acc_q[c] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						cmd_q   <= head;
						cnt_q   <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 2'd3) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			rd_vld_s1   <= (state_q == ST_READ);
			rd_first_s1 <= (cnt_q == 2'd0);
			rd_last_s1  <= (cnt_q == 2'd3);
			w_s1        <= wprod[WPROD_W-1:0];

			if (rd_vld_s1) begin
				for (int c = 0; c < NUM_CH; c++) begin
					acc_q[c] <= acc_next[c];
				end
			end

			if (rd_vld_s1 && rd_last_s1) begin
				out_valid_q <= 1'b1;
				out_data_q  <= result;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid                 = out_valid_q;
	assign rsp.payload.sampled_color = out_data_q;

	a_no_write_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> !ram_we)
		else $error("Pixel write issued during a sample read sequence.");

	a_last_read_sets_out: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 && rd_last_s1 |=> out_valid_q)
		else $error("Last neighbor read did not produce a result.");

	a_read_seq_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ && cnt_q == 2'd3 |=> state_q == ST_IDLE && rd_vld_s1 && rd_last_s1)
		else $error("Read sequence did not finish after four reads.");
endmodule

### sv/bilinear_pixel_sampler_top.sv
`timescale 1ns / 1ps
// Top level of the bilinear pixel sampler.
// The block holds a MAX_WIDTH by MAX_HEIGHT store of ARGB8888 pixels in one
// single-port memory and takes write and sample transactions through a
// two-entry command queue, so input keeps flowing while a result waits on the
// output. A sample takes the command, then makes four reads of the single
// memory port for the pixel and its right, lower and diagonal neighbors, and
// then finishes the last multiply-accumulate. The result passes the memory's
// read register and then the output register. Reading a pixel that was never
// written returns undefined data.
module bilinear_pixel_sampler_top #(
	parameter int MAX_WIDTH  = bps_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bps_pkg::DEF_MAX_HEIGHT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bps_pkg::CFG_W-1:0]     cfg_wdata,
	bps_stream_if.sink                    req,
	bps_stream_if.source                  rsp
);
	import bps_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	bps_cmd_t           push_cmd;
	bps_cmd_t           head;
	logic               push;
	logic               q_full;
	logic               pop;
	logic               head_valid;
	logic               ram_we;
	logic [AW-1:0]      ram_addr;
	logic [PIXEL_W-1:0] ram_wdata;
	logic [PIXEL_W-1:0] ram_rdata;

	bps_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.q_full    (q_full),
		.push      (push),
		.cmd       (push_cmd)
	);

	bps_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	bps_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.AW         (AW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.ram_we     (ram_we),
		.ram_addr   (ram_addr),
		.ram_wdata  (ram_wdata),
		.ram_rdata  (ram_rdata),
		.rsp        (rsp)
	);

	bps_ram #(
		.WIDTH (PIXEL_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);
endmodule

### sim/bilinear_pixel_sampler_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bilinear pixel sampler with a predicting scoreboard.
module bilinear_pixel_sampler_top_test;
	import bps_pkg::*;

	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 190;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 16;
	localparam int PRINT_CAP     = 100;

	class color_scoreboard;
		typedef int unsigned corner_addr_t [4];

		logic [PIXEL_W-1:0] pixels [];
		bit                 filled [];
		logic [CFG_W-1:0]   width_cfg;
		logic [CFG_W-1:0]   height_cfg;
		logic [PIXEL_W-1:0] expected_colors [$];
		int                 errors;

		function new();
			pixels = new[DEF_MAX_WIDTH * DEF_MAX_HEIGHT];
			filled = new[DEF_MAX_WIDTH * DEF_MAX_HEIGHT];
			width_cfg = SIZE_RESET;
			height_cfg = SIZE_RESET;
			errors = 0;
		endfunction

		task report(input string msg);
			errors++;
			if (errors <= PRINT_CAP)
				$display("ERROR at %0t ns: %s", $time, msg);
		endtask

		function void set_size(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
			if (idx == REG_IMAGE_WIDTH)
				width_cfg = v;
			else
				height_cfg = v;
		endfunction

		function int unsigned extent(input logic [CFG_W-1:0] v, input int unsigned limit);
			if (v < 1)
				return 1;
			if (v > limit)
				return limit;
			return v;
		endfunction

		// Store addresses of the pixel, its right, lower and diagonal neighbors.
		function void corners(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
				output corner_addr_t addr);
			int unsigned ew, eh, x, y, x1, y1;
			ew = extent(width_cfg, DEF_MAX_WIDTH);
			eh = extent(height_cfg, DEF_MAX_HEIGHT);
			x = cx[COORD_W-1:FRAC_W];
			y = cy[COORD_W-1:FRAC_W];
			if (x >= ew)
				x = ew - 1;
			if (y >= eh)
				y = eh - 1;
			x1 = (x + 1 >= ew) ? x : x + 1;
			y1 = (y + 1 >= eh) ? y : y + 1;
			addr[0] = y * DEF_MAX_WIDTH + x;
			addr[1] = y * DEF_MAX_WIDTH + x1;
			addr[2] = y1 * DEF_MAX_WIDTH + x;
			addr[3] = y1 * DEF_MAX_WIDTH + x1;
		endfunction

		function logic [PIXEL_W-1:0] blend(input logic [COORD_W-1:0] cx,
				input logic [COORD_W-1:0] cy);
			corner_addr_t       a;
			logic [PIXEL_W-1:0] c [4];
			logic [PIXEL_W-1:0] res;
			int unsigned        fx, fy, top, bot, v;
			corners(cx, cy, a);
			fx = cx[FRAC_W-1:0];
			fy = cy[FRAC_W-1:0];
			for (int i = 0; i < 4; i++)
				c[i] = pixels[a[i]];
			res = '0;
			for (int ch = 0; ch < NUM_CH; ch++) begin
				top = c[0][ch*CH_W +: CH_W] * (WEIGHT_ONE - fx) + c[1][ch*CH_W +: CH_W] * fx;
				bot = c[2][ch*CH_W +: CH_W] * (WEIGHT_ONE - fx) + c[3][ch*CH_W +: CH_W] * fx;
				v = (top * (WEIGHT_ONE - fy) + bot * fy) >> 8;
				res[ch*CH_W +: CH_W] = v[CH_W-1:0];
			end
			return res;
		endfunction

		function void note_request(input bps_in_t t);
			int unsigned addr;
			if (t.opcode == OP_WRITE) begin
				addr = t.coord_y_q4[COORD_W-1:FRAC_W] * DEF_MAX_WIDTH
					+ t.coord_x_q4[COORD_W-1:FRAC_W];
				pixels[addr] = t.pixel_value;
				filled[addr] = 1'b1;
			end else begin
				expected_colors.push_back(blend(t.coord_x_q4, t.coord_y_q4));
			end
		endfunction

		task check_color(input bps_out_t r);
			logic [PIXEL_W-1:0] want;
			if (expected_colors.size() == 0) begin
				report($sformatf("unexpected color %08h", r.sampled_color));
			end else begin
				want = expected_colors.pop_front();
				if (r.sampled_color !== want)
					report($sformatf("sampled_color %08h, expected %08h", r.sampled_color, want));
			end
		endtask

		function int pending();
			return expected_colors.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	bps_stream_if #(.payload_t(bps_in_t))  req_if ();
	bps_stream_if #(.payload_t(bps_out_t)) rsp_if ();

	bilinear_pixel_sampler_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req(req_if),
		.rsp(rsp_if)
	);

	color_scoreboard colors = new();

	bit hold_request  = 1'b0;
	bit sender_eager  = 1'b0;
	int send_run_left = 0;
	bit send_busy     = 1'b0;
	int items_sent    = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Alternates stretches of random waits with stretches of back-to-back traffic.
	function automatic int draw_wait(inout int run_left, inout bit busy);
		if (run_left == 0) begin
			run_left = $urandom_range(8, 40);
			busy = ($urandom_range(0, 2) != 0);
		end
		run_left--;
		return busy ? $urandom_range(0, 15) : 0;
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord(input int unsigned e);
		int lo, hi;
		case ($urandom_range(0, 3)) inside
			0, 1: return {INT_W'($urandom_range(0, 5)), FRAC_W'($urandom)};
			2: begin
				lo = int'(e) - 3;
				hi = int'(e) + 1;
				if (lo < 0)
					lo = 0;
				if (hi > DEF_MAX_WIDTH - 1)
					hi = DEF_MAX_WIDTH - 1;
				return {INT_W'($urandom_range(lo, hi)), FRAC_W'($urandom)};
			end
			default: return COORD_W'($urandom_range(0, 4095));
		endcase
	endfunction

	task automatic send(input bps_in_t t);
		int gap;
		gap = sender_eager ? 0 : draw_wait(send_run_left, send_busy);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.payload <= t;
		do @(posedge clk); while (!req_if.ready);
		colors.note_request(t);
		items_sent++;
	endtask

	task automatic put_pixel(input int unsigned x, input int unsigned y,
			input logic [PIXEL_W-1:0] v);
		bps_in_t t;
		t.opcode = OP_WRITE;
		t.coord_x_q4 = {INT_W'(x), FRAC_W'($urandom)};
		t.coord_y_q4 = {INT_W'(y), FRAC_W'($urandom)};
		t.pixel_value = v;
		send(t);
	endtask

	// Writes any neighbor that was never stored, then issues the sample.
	task automatic sample_point(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy);
		color_scoreboard::corner_addr_t a;
		bps_in_t t;
		colors.corners(cx, cy, a);
		for (int i = 0; i < 4; i++) begin
			if (!colors.filled[a[i]])
				put_pixel(a[i] % DEF_MAX_WIDTH, a[i] / DEF_MAX_WIDTH, $urandom);
		end
		t.opcode = OP_SAMPLE;
		t.coord_x_q4 = cx;
		t.coord_y_q4 = cy;
		t.pixel_value = $urandom;
		send(t);
	endtask

	task automatic random_item();
		logic [COORD_W-1:0] cx, cy;
		cx = pick_coord(colors.extent(colors.width_cfg, DEF_MAX_WIDTH));
		cy = pick_coord(colors.extent(colors.height_cfg, DEF_MAX_HEIGHT));
		if ($urandom_range(0, 9) < 3)
			put_pixel(cx[COORD_W-1:FRAC_W], cy[COORD_W-1:FRAC_W], $urandom);
		else
			sample_point(cx, cy);
	endtask

	task automatic wait_drained();
		req_if.valid <= 1'b0;
		while (colors.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		colors.set_size(REG_IMAGE_WIDTH, w);
		colors.set_size(REG_IMAGE_HEIGHT, h);
	endtask

	initial begin : result_sink
		int stall;
		int run_left;
		bit busy;
		run_left = 0;
		busy = 1'b0;
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				stall = HOLD_CYCLES;
				hold_request = 1'b0;
			end else begin
				stall = draw_wait(run_left, busy);
			end
			if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
			colors.check_color(rsp_if.payload);
		end
	end

	initial begin : stimulus
		logic [CFG_W-1:0] w_list [7];
		logic [CFG_W-1:0] h_list [7];
		logic [CFG_W-1:0] w, h;
		int target, k;
		w_list = '{9'd1, 9'd0, 9'd511, 9'd256, 9'd2, 9'd257, 9'd3};
		h_list = '{9'd1, 9'd511, 9'd0, 9'd2, 9'd256, 9'd3, 9'd256};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_wdata = '0;
		req_if.valid = 1'b0;
		req_if.payload = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner patterns at the origin, then the far corner where neighbors clamp.
		put_pixel(0, 0, 32'h0000_0000);
		put_pixel(1, 0, 32'hFFFF_FFFF);
		put_pixel(0, 1, 32'hFF00_FF00);
		put_pixel(1, 1, 32'h00FF_00FF);
		sample_point(12'h000, 12'h000);
		sample_point(12'h00F, 12'h00F);
		sample_point(12'h008, 12'h008);
		sample_point(12'h00F, 12'h000);
		sample_point(12'h000, 12'h00F);
		sample_point(12'hFFF, 12'hFFF);
		sample_point(12'hFF8, 12'h004);
		put_pixel(255, 255, 32'hFFFF_FFFF);
		sample_point(12'hFFF, 12'hFFF);
		sample_point(12'hFF0, 12'hFF7);

		for (int p = 0; p < PHASES; p++) begin
			if (p < 7) begin
				w = w_list[p];
				h = h_list[p];
			end else begin
				w = $urandom_range(0, 511);
				h = $urandom_range(0, 511);
			end
			apply_size(w, h);
			target = items_sent + PHASE_ITEMS;
			k = 0;
			while (items_sent < target) begin
				if (p == 3 && k == 40) begin
					hold_request = 1'b1;
					sender_eager = 1'b1;
				end
				if (p == 3 && k == 80)
					sender_eager = 1'b0;
				if (p == 6 && k == 60)
					wait_drained();
				random_item();
				k++;
			end
		end

		wait_drained();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (colors.pending() != 0)
			colors.report($sformatf("%0d expected colors never arrived", colors.pending()));
		if (colors.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
